FILE: hdl/rdbs_pkg.sv
// Shared constants and types for the RRIP replacement block with stream bypass.
`timescale 1ns / 1ps
package rdbs_pkg;

    localparam int NUM_SETS = 2048;
    localparam int NUM_WAYS = 16;
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = 4;
    localparam int ADDR_W   = 48;
    localparam int LINE_SH  = 6;
    localparam int LINE_W   = ADDR_W - LINE_SH;
    localparam int CNT_W    = 17;
    localparam int WIN_W    = 4;
    localparam int ROW_W    = NUM_WAYS * 2;

    localparam logic [1:0] RRPV_EVICT   = 2'd3;
    localparam logic [1:0] RRPV_FAR     = 2'd2;
    localparam logic [1:0] RRPV_HOT     = 2'd0;
    localparam logic [1:0] REUSE_INIT   = 2'd1;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_WINDOW  = 2'd1;

    localparam logic [CNT_W-1:0] DECAY_RESET  = 17'd4096;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd8;

    // Per-set stream detector entry
    typedef struct packed {
        logic [WIN_W-1:0]  window;
        logic              streaming;
        logic [1:0]        run;
        logic [LINE_W-1:0] last_line;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    // Memory requests from the sequencer
    typedef struct packed {
        logic [SET_W-1:0]  rd_addr;
        logic [SET_W-1:0]  wr_addr;
        logic              rrpv_we;
        logic [ROW_W-1:0]  rrpv_wd;
        logic              reuse_we;
        logic [ROW_W-1:0]  reuse_wd;
        logic              meta_we;
        logic [META_W-1:0] meta_wd;
    } t_ram_req;

endpackage

FILE: hdl/rdbs_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
`timescale 1ns / 1ps
module rdbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/rdbs_ctrl.sv
// Sequencer: clear pass, per-set read-modify-write, decay sweep, result register.
`timescale 1ns / 1ps
module rdbs_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [rdbs_pkg::SET_W-1:0]        i_set,
    input  logic [rdbs_pkg::WAY_W-1:0]        i_way,
    input  logic [rdbs_pkg::ADDR_W-1:0]       i_addr,
    input  logic                              i_hit,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rdbs_pkg::WAY_W-1:0]        o_victim,
    output logic                              o_bypass,
    input  logic                              i_cfg_valid,
    input  logic [rdbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rdbs_pkg::CNT_W-1:0]        i_cfg_data,
    output rdbs_pkg::t_ram_req                o_req,
    input  logic [rdbs_pkg::ROW_W-1:0]        i_rrpv_rd,
    input  logic [rdbs_pkg::ROW_W-1:0]        i_reuse_rd,
    input  logic [rdbs_pkg::META_W-1:0]       i_meta_rd
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOD, S_DECAY} t_state;

    t_state                          r_state;
    logic [rdbs_pkg::SET_W:0]        r_sw;
    logic                            r_dv;
    logic [rdbs_pkg::SET_W-1:0]      r_dwa;
    logic                            r_op;
    logic [rdbs_pkg::SET_W-1:0]      r_set;
    logic [rdbs_pkg::WAY_W-1:0]      r_way;
    logic [rdbs_pkg::LINE_W-1:0]     r_line;
    logic                            r_hit;
    logic [rdbs_pkg::CNT_W-1:0]      r_cnt;
    logic [rdbs_pkg::CNT_W-1:0]      r_interval;
    logic [rdbs_pkg::WIN_W-1:0]      r_window;
    logic                            r_ov;
    logic [rdbs_pkg::WAY_W-1:0]      r_victim;
    logic                            r_bypass;

    rdbs_pkg::t_meta                 meta_old;
    rdbs_pkg::t_meta                 meta_new;
    logic                            unit;
    logic                            active;
    logic [1:0]                      top;
    logic [1:0]                      age;
    logic [rdbs_pkg::WAY_W-1:0]      vic;
    logic [rdbs_pkg::ROW_W-1:0]      aged_row;
    logic [rdbs_pkg::ROW_W-1:0]      upd_rrpv;
    logic [rdbs_pkg::ROW_W-1:0]      upd_reuse;
    logic [rdbs_pkg::ROW_W-1:0]      dec_row;
    logic [1:0]                      old_reuse;
    logic                            way_ok;
    logic                            out_free;
    logic                            commit;
    logic [rdbs_pkg::CNT_W-1:0]      cnt_inc;
    logic                            decay_due;
    logic                            sweep_end;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_victim    = r_victim;
    assign o_bypass    = r_bypass;
    assign out_free    = !r_ov || i_out_ready;
    assign commit      = (r_state == S_MOD) && out_free;
    assign meta_old    = rdbs_pkg::t_meta'(i_meta_rd);
    assign way_ok      = (32'(r_way) < rdbs_pkg::NUM_WAYS);
    assign cnt_inc     = r_cnt + 1'b1;
    assign decay_due   = (cnt_inc >= r_interval);
    assign sweep_end   = (r_sw == (rdbs_pkg::SET_W + 1)'(rdbs_pkg::NUM_SETS));

    // Victim search: oldest RRPV, age the row up to the maximum, lowest way wins
    always_comb begin
        top = 2'd0;
        for (int w = 0; w < rdbs_pkg::NUM_WAYS; w++) begin
            if (i_rrpv_rd[2*w +: 2] > top) begin
                top = i_rrpv_rd[2*w +: 2];
            end
        end
        age = rdbs_pkg::RRPV_EVICT - top;
        vic = '0;
        for (int w = rdbs_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (i_rrpv_rd[2*w +: 2] == top) begin
                vic = rdbs_pkg::WAY_W'(w);
            end
        end
        for (int w = 0; w < rdbs_pkg::NUM_WAYS; w++) begin
            aged_row[2*w +: 2] = i_rrpv_rd[2*w +: 2] + age;
        end
    end

    // Stride detector on the set entry; compare one bit wider so the top line
    // does not wrap onto line zero
    always_comb begin
        meta_new = meta_old;
        unit = (meta_old.last_line != '0) &&
               (({1'b0, r_line} == {1'b0, meta_old.last_line} + 1'b1) ||
                ({1'b0, meta_old.last_line} == {1'b0, r_line} + 1'b1));
        if (unit) begin
            if (meta_old.run != 2'd3) begin
                meta_new.run = meta_old.run + 1'b1;
            end
            if ((meta_new.run == 2'd3) && !meta_old.streaming) begin
                meta_new.streaming = 1'b1;
                meta_new.window    = r_window;
            end
        end else begin
            meta_new.run       = 2'd0;
            meta_new.streaming = 1'b0;
            meta_new.window    = '0;
        end
        meta_new.last_line = r_line;
        if (meta_new.streaming && (meta_new.window != '0)) begin
            meta_new.window = meta_new.window - 1'b1;
        end
        active = meta_new.streaming && (meta_new.window != '0);
    end

    // Hit promotion and fill insertion on the addressed way
    always_comb begin
        upd_rrpv  = i_rrpv_rd;
        upd_reuse = i_reuse_rd;
        old_reuse = i_reuse_rd[2*r_way +: 2];
        if (way_ok) begin
            if (r_hit) begin
                upd_rrpv[2*r_way +: 2] = rdbs_pkg::RRPV_HOT;
                if (old_reuse != 2'd3) begin
                    upd_reuse[2*r_way +: 2] = old_reuse + 1'b1;
                end
            end else if (active) begin
                upd_rrpv[2*r_way +: 2] = rdbs_pkg::RRPV_EVICT;
            end else begin
                unique case (old_reuse)
                    2'd0:    upd_rrpv[2*r_way +: 2] = rdbs_pkg::RRPV_EVICT;
                    2'd1:    upd_rrpv[2*r_way +: 2] = rdbs_pkg::RRPV_FAR;
                    default: upd_rrpv[2*r_way +: 2] = rdbs_pkg::RRPV_HOT;
                endcase
                upd_reuse[2*r_way +: 2] = rdbs_pkg::REUSE_INIT;
            end
        end
    end

    // Saturating decrement of a whole reuse row
    always_comb begin
        for (int w = 0; w < rdbs_pkg::NUM_WAYS; w++) begin
            dec_row[2*w +: 2] = (i_reuse_rd[2*w +: 2] != 2'd0) ?
                                i_reuse_rd[2*w +: 2] - 1'b1 : 2'd0;
        end
    end

    // Memory requests
    always_comb begin
        o_req          = '0;
        o_req.rd_addr  = r_set;
        o_req.wr_addr  = r_set;
        o_req.rrpv_wd  = (r_op == rdbs_pkg::OP_VICTIM) ? aged_row : upd_rrpv;
        o_req.reuse_wd = upd_reuse;
        o_req.meta_wd  = rdbs_pkg::META_W'(meta_new);
        unique case (r_state)
            S_CLEAR: begin
                o_req.wr_addr  = r_sw[rdbs_pkg::SET_W-1:0];
                o_req.rrpv_we  = 1'b1;
                o_req.rrpv_wd  = {rdbs_pkg::NUM_WAYS{rdbs_pkg::RRPV_EVICT}};
                o_req.reuse_we = 1'b1;
                o_req.reuse_wd = {rdbs_pkg::NUM_WAYS{rdbs_pkg::REUSE_INIT}};
                o_req.meta_we  = 1'b1;
                o_req.meta_wd  = '0;
            end
            S_IDLE: begin
                o_req.rd_addr = i_set;
            end
            S_MOD: begin
                o_req.rrpv_we  = commit;
                o_req.reuse_we = commit && (r_op == rdbs_pkg::OP_UPDATE);
                o_req.meta_we  = commit && (r_op == rdbs_pkg::OP_UPDATE);
            end
            S_DECAY: begin
                o_req.rd_addr  = r_sw[rdbs_pkg::SET_W-1:0];
                o_req.wr_addr  = r_dwa;
                o_req.reuse_we = r_dv;
                o_req.reuse_wd = dec_row;
            end
            default: begin
                o_req.rd_addr = r_set;
            end
        endcase
    end

    // State, captured item, counters, config and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_sw       <= '0;
            r_dv       <= 1'b0;
            r_cnt      <= '0;
            r_interval <= rdbs_pkg::DECAY_RESET;
            r_window   <= rdbs_pkg::WINDOW_RESET;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == rdbs_pkg::CFG_DECAY_INTERVAL) begin
                    r_interval <= i_cfg_data;
                end else if (i_cfg_index == rdbs_pkg::CFG_STREAM_WINDOW) begin
                    r_window <= i_cfg_data[rdbs_pkg::WIN_W-1:0];
                end
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == (rdbs_pkg::SET_W + 1)'(rdbs_pkg::NUM_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_set   <= i_set;
                        r_way   <= i_way;
                        r_line  <= i_addr[rdbs_pkg::ADDR_W-1:rdbs_pkg::LINE_SH];
                        r_hit   <= i_hit;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        if (r_op == rdbs_pkg::OP_VICTIM) begin
                            r_victim <= vic;
                            r_bypass <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_victim <= '0;
                            r_bypass <= active;
                            if (decay_due) begin
                                r_cnt   <= '0;
                                r_sw    <= '0;
                                r_dv    <= 1'b0;
                                r_state <= S_DECAY;
                            end else begin
                                r_cnt   <= cnt_inc;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_DECAY: begin
                    // Read row k while writing back row k-1
                    if (!sweep_end) begin
                        r_sw  <= r_sw + 1'b1;
                        r_dv  <= 1'b1;
                        r_dwa <= r_sw[rdbs_pkg::SET_W-1:0];
                    end else begin
                        r_dv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/rrip_dead_block_stream_replacement.sv
// Top level: SRRIP replacement with dead-block reuse counters and stream bypass.
//
//  channel   | direction | beat contents
//  s_axis    | in        | tuser: op; tdata: set_index, way_index, phys_addr, was_hit
//  m_axis    | out       | tdata: victim_way, stream_bypass
//  cfg       | in        | i_cfg_index selects register, i_cfg_data carries value
//
// Each item is accepted with the set read issued, then gets a read-modify-write
// in the modify state on the set's RRPV, reuse and stream-detector rows.
// An update that triggers decay then runs a sweep over the reuse rows of every set.
// After reset a clearing pass over all NUM_SETS (2048) sets runs; no item is taken.
// A result waiting on m_axis holds the next item in its modify cycle.
`timescale 1ns / 1ps
module rrip_dead_block_stream_replacement (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [63:0]                    s_axis_tdata,  // set_index, way_index, phys_addr, was_hit
    input  logic                           s_axis_tuser,  // op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // victim_way, stream_bypass, zero pad
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rdbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rdbs_pkg::CNT_W-1:0]     i_cfg_data
);

    rdbs_pkg::t_ram_req               req;
    logic [rdbs_pkg::ROW_W-1:0]       rrpv_rd;
    logic [rdbs_pkg::ROW_W-1:0]       reuse_rd;
    logic [rdbs_pkg::META_W-1:0]      meta_rd;
    logic [rdbs_pkg::WAY_W-1:0]       victim;
    logic                             bypass;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {3'b000, bypass, victim};

    rdbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_set       (s_axis_tdata[10:0]),
        .i_way       (s_axis_tdata[14:11]),
        .i_addr      (s_axis_tdata[62:15]),
        .i_hit       (s_axis_tdata[63]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_victim    (victim),
        .o_bypass    (bypass),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_req       (req),
        .i_rrpv_rd   (rrpv_rd),
        .i_reuse_rd  (reuse_rd),
        .i_meta_rd   (meta_rd)
    );

    // RRPV rows, one per set
    rdbs_ram #(.WIDTH(rdbs_pkg::ROW_W), .DEPTH(rdbs_pkg::NUM_SETS)) u_rrpv_ram (
        .i_clk     (i_clk),
        .i_we      (req.rrpv_we),
        .i_wr_addr (req.wr_addr),
        .i_wr_data (req.rrpv_wd),
        .i_rd_addr (req.rd_addr),
        .o_rd_data (rrpv_rd)
    );

    // Reuse counter rows, one per set
    rdbs_ram #(.WIDTH(rdbs_pkg::ROW_W), .DEPTH(rdbs_pkg::NUM_SETS)) u_reuse_ram (
        .i_clk     (i_clk),
        .i_we      (req.reuse_we),
        .i_wr_addr (req.wr_addr),
        .i_wr_data (req.reuse_wd),
        .i_rd_addr (req.rd_addr),
        .o_rd_data (reuse_rd)
    );

    // Stream detector entries, one per set
    rdbs_ram #(.WIDTH(rdbs_pkg::META_W), .DEPTH(rdbs_pkg::NUM_SETS)) u_meta_ram (
        .i_clk     (i_clk),
        .i_we      (req.meta_we),
        .i_wr_addr (req.wr_addr),
        .i_wr_data (req.meta_wd),
        .i_rd_addr (req.rd_addr),
        .o_rd_data (meta_rd)
    );

    // Only one item in flight: ready drops right after an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another is in flight");

    // A bypass result always carries way zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
        else $error("bypass result with nonzero way");

    // Memory writes never collide with item acceptance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !req.rrpv_we && !req.reuse_we && !req.meta_we)
        else $error("memory write while accepting");

    // Pad bits of the result stay zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
        else $error("result pad bits set");

endmodule

FILE: dv/tb_rrip_dead_block_stream_replacement.sv
// Testbench for the RRIP replacement block: random streams, own policy model, result check.
`timescale 1ns / 1ps
module tb_rrip_dead_block_stream_replacement;

    typedef struct {
        logic                        op;
        logic [rdbs_pkg::SET_W-1:0]  set_idx;
        logic [rdbs_pkg::WAY_W-1:0]  way_idx;
        logic [rdbs_pkg::ADDR_W-1:0] addr;
        logic                        hit;
    } t_access;

    typedef struct {
        logic [rdbs_pkg::WAY_W-1:0] victim;
        logic                       bypass;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [rdbs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rdbs_pkg::CNT_W-1:0] i_cfg_data = '0;

    // Model state
    logic [1:0]                  rrpv_mem [rdbs_pkg::NUM_SETS*rdbs_pkg::NUM_WAYS];
    logic [1:0]                  reuse_mem [rdbs_pkg::NUM_SETS*rdbs_pkg::NUM_WAYS];
    logic [rdbs_pkg::LINE_W-1:0] last_line_mem [rdbs_pkg::NUM_SETS];
    logic [1:0]                  run_mem [rdbs_pkg::NUM_SETS];
    logic                        stream_mem [rdbs_pkg::NUM_SETS];
    logic [rdbs_pkg::WIN_W-1:0]  window_mem [rdbs_pkg::NUM_SETS];
    logic [rdbs_pkg::CNT_W-1:0]  upd_count;
    logic [rdbs_pkg::CNT_W-1:0]  decay_cfg;
    logic [rdbs_pkg::WIN_W-1:0]  window_cfg;

    t_access  access_q [$];
    t_verdict verdict_q [$];
    t_access  on_bus;
    int src_idle = 23;
    int dst_idle = 82;
    bit hold_src = 1'b0;
    int fail_count = 0;

    rrip_dead_block_stream_replacement i_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [rdbs_pkg::WAY_W-1:0] find_victim(int s);
        int top;
        int age;
        top = 0;
        for (int w = 0; w < rdbs_pkg::NUM_WAYS; w++)
            if (rrpv_mem[s*rdbs_pkg::NUM_WAYS+w] > top) top = rrpv_mem[s*rdbs_pkg::NUM_WAYS+w];
        age = int'(rdbs_pkg::RRPV_EVICT) - top;
        for (int w = 0; w < rdbs_pkg::NUM_WAYS; w++)
            rrpv_mem[s*rdbs_pkg::NUM_WAYS+w] = 2'(rrpv_mem[s*rdbs_pkg::NUM_WAYS+w] + age);
        for (int w = 0; w < rdbs_pkg::NUM_WAYS; w++)
            if (rrpv_mem[s*rdbs_pkg::NUM_WAYS+w] == rdbs_pkg::RRPV_EVICT)
                return rdbs_pkg::WAY_W'(w);
        return '0;
    endfunction

    // Stride detector: returns whether the set's window is active after the step
    function automatic logic track_stride(int s, logic [rdbs_pkg::ADDR_W-1:0] a);
        logic [63:0] cur;
        logic [63:0] prev;
        logic unit_step;
        cur  = 64'(a) >> rdbs_pkg::LINE_SH;
        prev = 64'(last_line_mem[s]);
        unit_step = (prev != 0) && (cur == prev + 1 || prev == cur + 1);
        if (unit_step) begin
            if (run_mem[s] < 3) run_mem[s]++;
            if (run_mem[s] == 3 && !stream_mem[s]) begin
                stream_mem[s] = 1'b1;
                window_mem[s] = window_cfg;
            end
        end else begin
            run_mem[s] = '0;
            stream_mem[s] = 1'b0;
            window_mem[s] = '0;
        end
        last_line_mem[s] = cur[rdbs_pkg::LINE_W-1:0];
        if (stream_mem[s] && window_mem[s] > 0) window_mem[s]--;
        return stream_mem[s] && window_mem[s] > 0;
    endfunction

    function automatic t_verdict predict_policy(t_access t);
        t_verdict v;
        int idx;
        v.victim = '0;
        v.bypass = 1'b0;
        if (t.op == rdbs_pkg::OP_VICTIM) begin
            v.victim = find_victim(t.set_idx);
            return v;
        end
        v.bypass = track_stride(t.set_idx, t.addr);
        idx = t.set_idx * rdbs_pkg::NUM_WAYS + t.way_idx;
        if (t.hit) begin
            rrpv_mem[idx] = rdbs_pkg::RRPV_HOT;
            if (reuse_mem[idx] < 3) reuse_mem[idx]++;
        end else if (v.bypass) begin
            rrpv_mem[idx] = rdbs_pkg::RRPV_EVICT;
        end else begin
            case (reuse_mem[idx])
                2'd0:    rrpv_mem[idx] = rdbs_pkg::RRPV_EVICT;
                2'd1:    rrpv_mem[idx] = rdbs_pkg::RRPV_FAR;
                default: rrpv_mem[idx] = rdbs_pkg::RRPV_HOT;
            endcase
            reuse_mem[idx] = rdbs_pkg::REUSE_INIT;
        end
        upd_count++;
        if (upd_count >= decay_cfg) begin
            for (int i = 0; i < rdbs_pkg::NUM_SETS*rdbs_pkg::NUM_WAYS; i++)
                if (reuse_mem[i] > 0) reuse_mem[i]--;
            upd_count = '0;
        end
        return v;
    endfunction

    // Drive input beats and predict each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) verdict_q.push_back(predict_policy(on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (access_q.size() > 0 && !hold_src && $urandom_range(99) >= src_idle) begin
                    on_bus = access_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= on_bus.op;
                    s_axis_tdata  <= {on_bus.hit, on_bus.addr, on_bus.way_idx, on_bus.set_idx};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check result beats against the oldest prediction
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_axis_tdata[3:0] !== exp_v.victim) begin
                        $display("%0t: victim_way expected %0d actual %0d",
                                 $time, exp_v.victim, m_axis_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[4] !== exp_v.bypass) begin
                        $display("%0t: stream_bypass expected %0b actual %0b",
                                 $time, exp_v.bypass, m_axis_tdata[4]);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= dst_idle);
        end
    end

    function automatic t_access mk(logic op, int s, int w, logic [rdbs_pkg::ADDR_W-1:0] a,
                                   logic h);
        t_access t;
        t.op = op;
        t.set_idx = rdbs_pkg::SET_W'(s);
        t.way_idx = rdbs_pkg::WAY_W'(w);
        t.addr = a;
        t.hit = h;
        return t;
    endfunction

    function automatic logic [rdbs_pkg::ADDR_W-1:0] rand_addr();
        return rdbs_pkg::ADDR_W'({$urandom, $urandom});
    endfunction

    // Mostly unit-stride runs on a few sets, the rest noise and broken runs
    task automatic add_random(int n);
        int made;
        int s;
        int len;
        logic [63:0] line;
        logic neg;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 65) begin
                s = ($urandom_range(3) == 0) ? $urandom_range(rdbs_pkg::NUM_SETS-1)
                                             : $urandom_range(7);
                line = ($urandom_range(4) == 0) ? 64'($urandom_range(5))
                                                : 64'(rand_addr() >> rdbs_pkg::LINE_SH);
                neg = 1'($urandom_range(1));
                len = $urandom_range(2, 10);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(3) == 0) begin
                        access_q.push_back(mk(rdbs_pkg::OP_VICTIM, s, $urandom_range(15),
                                              rand_addr(), 1'($urandom_range(1))));
                        made++;
                    end
                    access_q.push_back(mk(rdbs_pkg::OP_UPDATE, s, $urandom_range(15),
                                          {line[rdbs_pkg::LINE_W-1:0], 6'($urandom_range(63))},
                                          1'($urandom_range(1))));
                    made++;
                    if ($urandom_range(19) == 0) line = line + 2;
                    else line = neg ? line - 1 : line + 1;
                end
            end else begin
                access_q.push_back(mk(1'($urandom_range(1)),
                                      $urandom_range(rdbs_pkg::NUM_SETS-1),
                                      $urandom_range(15), rand_addr(),
                                      1'($urandom_range(1))));
                made++;
            end
        end
    endtask

    task automatic drain();
        wait (access_q.size() == 0 && !s_axis_tvalid && verdict_q.size() == 0);
        // let a decay sweep finish
        repeat (rdbs_pkg::NUM_SETS + 64) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rdbs_pkg::CFG_IDX_W-1:0] idx,
                             logic [rdbs_pkg::CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == rdbs_pkg::CFG_DECAY_INTERVAL) decay_cfg = val;
        else if (idx == rdbs_pkg::CFG_STREAM_WINDOW) window_cfg = val[rdbs_pkg::WIN_W-1:0];
        @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < rdbs_pkg::NUM_SETS*rdbs_pkg::NUM_WAYS; i++) begin
            rrpv_mem[i] = rdbs_pkg::RRPV_EVICT;
            reuse_mem[i] = rdbs_pkg::REUSE_INIT;
        end
        for (int i = 0; i < rdbs_pkg::NUM_SETS; i++) begin
            last_line_mem[i] = '0;
            run_mem[i] = '0;
            stream_mem[i] = 1'b0;
            window_mem[i] = '0;
        end
        upd_count = '0;
        decay_cfg = rdbs_pkg::DECAY_RESET;
        window_cfg = rdbs_pkg::WINDOW_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fresh set victim, fills from reuse levels 1 and 3, hit, streams
        access_q.push_back(mk(rdbs_pkg::OP_VICTIM, 0, 0, '0, 1'b0));
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 0, 0, 48'h40, 1'b0));
        access_q.push_back(mk(rdbs_pkg::OP_VICTIM, 0, 0, '0, 1'b0));
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 0, 0, 48'h40, 1'b1));
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 0, 0, 48'h40, 1'b1));
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 0, 0, 48'h40, 1'b0));
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 0, 15, 48'h40, 1'b1));
        access_q.push_back(mk(rdbs_pkg::OP_VICTIM, 0, 0, '0, 1'b0));
        // line zero never counts as a stride origin
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 1, 3, 48'h0, 1'b0));
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 1, 3, 48'h40, 1'b0));
        // ascending stream
        for (int k = 2; k < 8; k++)
            access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 1, k,
                                  48'(k) << rdbs_pkg::LINE_SH, 1'b0));
        // descending stream at the top of the address space
        for (int k = 0; k < 5; k++)
            access_q.push_back(mk(rdbs_pkg::OP_UPDATE, rdbs_pkg::NUM_SETS-1, 15,
                                  48'hFFFF_FFFF_FFFF - (48'(k) << rdbs_pkg::LINE_SH), 1'b0));
        // top line followed by line zero is not a unit stride
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 2, 1, 48'hFFFF_FFFF_FFFF, 1'b0));
        access_q.push_back(mk(rdbs_pkg::OP_UPDATE, 2, 1, 48'h0, 1'b0));
        access_q.push_back(mk(rdbs_pkg::OP_VICTIM, rdbs_pkg::NUM_SETS-1, 15,
                              48'hFFFF_FFFF_FFFF, 1'b1));
        access_q.push_back(mk(rdbs_pkg::OP_VICTIM, 1, 0, '0, 1'b0));
        drain();

        // Decay on every update, widest window
        write_reg(rdbs_pkg::CFG_DECAY_INTERVAL, 0);
        write_reg(rdbs_pkg::CFG_STREAM_WINDOW, 15);
        add_random(12);
        drain();
        write_reg(rdbs_pkg::CFG_DECAY_INTERVAL, 1);
        write_reg(rdbs_pkg::CFG_STREAM_WINDOW, 0);
        add_random(12);
        drain();

        src_idle = 82;
        dst_idle = 23;
        write_reg(rdbs_pkg::CFG_DECAY_INTERVAL, 7);
        write_reg(rdbs_pkg::CFG_STREAM_WINDOW, 3);
        write_reg(2'd2, 5);
        write_reg(2'd3, 1);
        add_random(120);
        drain();

        write_reg(rdbs_pkg::CFG_DECAY_INTERVAL, 65536);
        write_reg(rdbs_pkg::CFG_STREAM_WINDOW, 15);
        add_random(350);
        // hold the sender until every result is back
        wait (access_q.size() < 200);
        hold_src = 1'b1;
        wait (!s_axis_tvalid && verdict_q.size() == 0);
        hold_src = 1'b0;
        add_random(350);
        drain();

        src_idle = 0;
        dst_idle = 0;
        write_reg(rdbs_pkg::CFG_DECAY_INTERVAL, 17'h1FFFF);
        write_reg(rdbs_pkg::CFG_STREAM_WINDOW, 8);
        add_random(800);
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: rrip_dead_block_stream_replacement.f
hdl/rdbs_pkg.sv
hdl/rdbs_ram.sv
hdl/rdbs_ctrl.sv
hdl/rrip_dead_block_stream_replacement.sv
dv/tb_rrip_dead_block_stream_replacement.sv
